[design/assert_macros.svh]
// assertion macros shared by the affine chain concatenator rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ACC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/acc_pkg.sv]
// shared constants and types for the affine chain concatenator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package acc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_ROWS       = 3;
    localparam int NUM_COLS       = 4;

    // row codes of an item
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_MID   = 2'd1;
    localparam logic [1:0] ROW_LAST  = 2'd2;
    localparam logic [1:0] ROW_NONE  = 2'd3;

    // control of the item held in the multiply stage
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       first;
        logic       endl;
    } t_s1_ctl;

endpackage

[design/acc_lane.sv]
// one lane: holds one row of the running product and of the partial sum,
// with four multipliers and the saturating accumulate stage; uses acc_pkg
`timescale 1ns / 1ps

module acc_lane #(
    parameter int DATA_WIDTH = acc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = acc_pkg::FRAC_BITS_DEF,
    parameter int LANE_IDX   = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [1:0]                   i_row,
    input  logic signed [DATA_WIDTH-1:0] i_col [acc_pkg::NUM_COLS],
    input  acc_pkg::t_s1_ctl             i_ctl,
    input  logic                         i_upd,
    output logic signed [DATA_WIDTH-1:0] o_p_next [acc_pkg::NUM_COLS]
);
    import acc_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam logic signed [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // product shifted down with floor rounding, then clamped
    function automatic logic signed [DATA_WIDTH-1:0] fix_prod(
        input logic signed [PW-1:0] p
    );
        logic signed [PW-1:0] q;
        q = p >>> FRAC_BITS;
        if (q > PW'(MAX_V)) begin
            return MAX_V;
        end else if (q < PW'(MIN_V)) begin
            return MIN_V;
        end
        return q[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? MIN_V : MAX_V;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    logic signed [DATA_WIDTH-1:0] r_p    [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] r_ps   [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] r_col  [NUM_COLS];
    logic signed [PW-1:0]         r_prod [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] n_p    [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] n_ps   [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_mcand;
    logic signed [PW-1:0]         w_prod [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_fix  [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_sum  [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_fold [NUM_COLS];

    // element of this lane's product row picked by the incoming row
    always_comb begin
        case (i_row)
            ROW_FIRST: w_mcand = r_p[0];
            ROW_MID:   w_mcand = r_p[1];
            default:   w_mcand = r_p[2];
        endcase
    end

    always_comb begin
        for (int j = 0; j < NUM_COLS; j++) begin
            w_prod[j] = PW'(w_mcand) * PW'(i_col[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < NUM_COLS; j++) begin
                r_prod[j] <= w_prod[j];
                r_col[j]  <= i_col[j];
            end
        end
    end

    // accumulate stage
    always_comb begin
        for (int j = 0; j < NUM_COLS; j++) begin
            w_fix[j]  = fix_prod(r_prod[j]);
            w_sum[j]  = sat_add(r_ps[j], w_fix[j]);
            w_fold[j] = (j == NUM_COLS - 1) ? sat_add(w_sum[j], r_p[NUM_COLS-1]) : w_sum[j];
        end
        n_p  = r_p;
        n_ps = r_ps;
        if (i_upd && i_ctl.valid) begin
            if (i_ctl.first) begin
                if (i_ctl.row == 2'(LANE_IDX)) begin
                    n_ps = r_col;
                end
                if (i_ctl.row == ROW_LAST) begin
                    n_p = (LANE_IDX == NUM_ROWS - 1) ? r_col : r_ps;
                end
            end else begin
                case (i_ctl.row)
                    ROW_FIRST: n_ps = w_fix;
                    ROW_MID:   n_ps = w_sum;
                    ROW_LAST:  n_p  = w_fold;
                    default:   n_p  = r_p;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_COLS; j++) begin
                r_p[j]  <= '0;
                r_ps[j] <= '0;
            end
        end else begin
            r_p  <= n_p;
            r_ps <= n_ps;
        end
    end

    assign o_p_next = n_p;

endmodule

[design/acc_merge.sv]
// merging stage: gathers the three lane rows of a finished product and
// sends them out one row per transfer; uses acc_pkg
`timescale 1ns / 1ps

module acc_merge #(
    parameter int DATA_WIDTH = acc_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic signed [DATA_WIDTH-1:0] i_p [acc_pkg::NUM_ROWS][acc_pkg::NUM_COLS],
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic                         o_free,
    output logic [1:0]                   o_row,
    output logic signed [DATA_WIDTH-1:0] o_data [acc_pkg::NUM_COLS],
    output logic                         o_last
);
    import acc_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_buf [NUM_ROWS][NUM_COLS];
    logic                         r_valid;
    logic [1:0]                   r_cnt;
    logic                         w_xfer;
    logic                         w_done;

    assign w_xfer = r_valid && i_ready;
    assign w_done = w_xfer && (r_cnt == ROW_LAST);
    assign o_free = !r_valid || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= ROW_FIRST;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= ROW_FIRST;
        end else if (w_xfer) begin
            r_valid <= !w_done;
            r_cnt   <= r_cnt + 2'd1;
        end
    end

    // rows move up so the head row is always the one on the port
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_p;
        end else if (w_xfer) begin
            for (int r = 0; r < NUM_ROWS - 1; r++) begin
                r_buf[r] <= r_buf[r+1];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_cnt;
    assign o_data  = r_buf[0];
    assign o_last  = (r_cnt == ROW_LAST);

endmodule

[design/affine_chain_concatenator_top.sv]
// top level of the affine chain concatenator: input control, three row lanes
// and the output merging stage; uses acc_pkg, acc_lane, acc_merge, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Concatenates chains of 3x4 affine matrices in signed fixed point
// (DATA_WIDTH bits, FRAC_BITS fraction bits, Q16.16 by default). Each link
// arrives as three row transfers in order 0, 1, 2; the first link of a chain
// becomes the running product and every later link is folded in as
// product * link, with an implied bottom row 0,0,0,1. Products are shifted
// down rounding toward minus infinity and clamped; every sum saturates.
// After row 2 of a link flagged end_link, the three rows of the product go
// out as three transfers, the last with o_last_row set. Rate: one row per
// cycle, except that o_ready is low while row 2 of a link is in the
// multiply stage, because the running product is rewritten in the
// accumulate stage while the next row's multipliers read it. The first
// result row is on the port once row 2 of the end link has left the
// multiply stage and been loaded into the merging stage; emission of one
// chain overlaps the input of the next, and an end link's row 2 waits in the
// multiply stage only if the previous three rows have not all left.
// Rows coded 3 are taken and dropped. No clearing pass after reset.
module affine_chain_concatenator_top #(
    parameter int DATA_WIDTH = acc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = acc_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_row_index,
    input  logic signed [DATA_WIDTH-1:0] i_col0,
    input  logic signed [DATA_WIDTH-1:0] i_col1,
    input  logic signed [DATA_WIDTH-1:0] i_col2,
    input  logic signed [DATA_WIDTH-1:0] i_col3,
    input  logic                         i_first_link,
    input  logic                         i_end_link,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_out_row,
    output logic signed [DATA_WIDTH-1:0] o_out0,
    output logic signed [DATA_WIDTH-1:0] o_out1,
    output logic signed [DATA_WIDTH-1:0] o_out2,
    output logic signed [DATA_WIDTH-1:0] o_out3,
    output logic                         o_last_row
);
    import acc_pkg::*;

    t_s1_ctl                      r_s1;           // item in the multiply stage
    logic                         r_in_first_link; // latched from each row 0
    logic                         w_accept;
    logic                         w_load;
    logic                         w_first;
    logic                         w_s1_emit;
    logic                         w_s1_go;
    logic                         w_buf_free;
    logic signed [DATA_WIDTH-1:0] w_col   [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_p_next [NUM_ROWS][NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_out   [NUM_COLS];

    assign w_col[0] = i_col0;
    assign w_col[1] = i_col1;
    assign w_col[2] = i_col2;
    assign w_col[3] = i_col3;

    // input transfer; a row-3 item is consumed without touching anything
    assign w_accept = i_valid && o_ready;
    assign w_load   = w_accept && (i_row_index != ROW_NONE);

    // rows 1 and 2 follow the flag that row 0 latched
    assign w_first = (i_row_index == ROW_FIRST) ? i_first_link : r_in_first_link;

    // an end row 2 may only enter accumulate when the output buffer can take it
    assign w_s1_emit = r_s1.valid && (r_s1.row == ROW_LAST) && r_s1.endl;
    assign w_s1_go   = !w_s1_emit || w_buf_free;

    // hold off the row after a row 2 until the product has been rewritten
    assign o_ready = !r_s1.valid || (w_s1_go && (r_s1.row != ROW_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1            <= '0;
            r_in_first_link <= 1'b0;
        end else begin
            if (w_load) begin
                r_s1.valid <= 1'b1;
                r_s1.row   <= i_row_index;
                r_s1.first <= w_first;
                r_s1.endl  <= i_end_link;
            end else if (w_s1_go) begin
                r_s1.valid <= 1'b0;
            end
            if (w_accept && (i_row_index == ROW_FIRST)) begin
                r_in_first_link <= i_first_link;
            end
        end
    end

    // one lane per product row: multiply stage then accumulate stage
    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_lane
        acc_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .LANE_IDX   (g)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (w_load),
            .i_row    (i_row_index),
            .i_col    (w_col),
            .i_ctl    (r_s1),
            .i_upd    (w_s1_go),
            .o_p_next (w_p_next[g])
        );
    end

    // merging stage takes the new product rows as they are written
    acc_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_emit && w_s1_go),
        .i_p     (w_p_next),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_free  (w_buf_free),
        .o_row   (o_out_row),
        .o_data  (w_out),
        .o_last  (o_last_row)
    );

    assign o_out0 = w_out[0];
    assign o_out1 = w_out[1];
    assign o_out2 = w_out[2];
    assign o_out3 = w_out[3];

    // row 2 in the multiply stage must block the next input transfer
    `ACC_ASSERT_IMP(a_row2_interlock, i_clk, i_rst_n,
        r_s1.valid && (r_s1.row == ROW_LAST), !o_ready, "input taken behind a row 2")
    // an end row 2 that leaves the multiply stage starts an emission at row 0
    `ACC_ASSERT_NXT(a_emit_start, i_clk, i_rst_n, w_s1_emit && w_s1_go,
        o_valid && (o_out_row == ROW_FIRST), "emission did not start at row 0")
    // rows leave in order without gaps
    `ACC_ASSERT_NXT(a_row_step, i_clk, i_rst_n,
        o_valid && i_ready && (o_out_row != ROW_LAST),
        o_valid && (o_out_row == $past(o_out_row) + 2'd1), "result rows out of order")
    // the multiply stage only stalls behind a pending emission
    `ACC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, r_s1.valid && !w_s1_go, o_valid,
        "stall without pending emission")

endmodule
